FILE: hdl/vr4_pkg.sv
// ----------------------------------------------------------------------------
// vr4_pkg
// Widths and types shared by the 4-D vector rejection pipeline.
// ----------------------------------------------------------------------------
package vr4_pkg;

    localparam int W    = 32;           // word bits
    localparam int F    = 16;           // fraction bits
    localparam int PW   = 2 * W;        // one product
    localparam int SAUW = 2 * W + 2;    // signed dot(a,u)
    localparam int SUUW = 2 * W + 1;    // unsigned dot(u,u)
    localparam int MAGW = SAUW - 1;     // |dot(a,u)|
    localparam int NW   = MAGW + F;     // dividend
    localparam int QB   = W + 1;        // quotient bits resolved by the divider
    localparam int RW   = SUUW + QB + 1;// partial remainder
    localparam int TW   = 2 * W + 2;    // a*2^F - c*u

    typedef logic [3:0][W-1:0] vec_t;

    typedef struct packed {
        vec_t a;
        vec_t u;
        logic zero;
        logic neg;
        logic ovf;
    } side_t;

endpackage

FILE: hdl/vector_rejection_4d.sv
// ----------------------------------------------------------------------------
// vector_rejection_4d
// Rejection of a 4-D vector a from a direction u, Q16.16, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one pair (a, u) per transaction; m_ channel returns
//   a - c*u, c = dot(a,u)/dot(u,u), plus saturation and zero-direction flags.
//   Throughput: one transaction per cycle while s_tready is high.
//   Stages: 3 dot stages, 33 divider stages of one quotient bit each
//   plus a rounding stage, 4 residual stages, output register. The divider
//   sets the depth.
//   Reset clears every valid bit; no result is pending afterwards.
//   A stalled receiver: a result arriving while the output register is held
//   goes to a skid register, then the whole pipeline freezes with s_tready
//   low; nothing is lost or repeated, and it restarts once the skid drains.
// ----------------------------------------------------------------------------
module vector_rejection_4d
    import vr4_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // a_0, a_1, a_2, a_3, u_0, u_1, u_2, u_3 (32 bits each, lowest first)
    input  logic [255:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // res_0, res_1, res_2, res_3, coef (32 bits each, lowest first)
    output logic [159:0] m_tdata,
    // saturated, zero_direction
    output logic [1:0]   m_tuser
);

    typedef struct packed {
        vec_t         res;
        logic [W-1:0] coef;
        logic         sat;
        logic         zero;
    } result_t;

    logic            en;
    vec_t            a, u;
    logic            d_valid;
    side_t           d_side;
    logic [NW-1:0]   d_num;
    logic [SUUW-1:0] d_den;
    logic            q_valid;
    side_t           q_side;
    logic [QB:0]     q_quo;
    logic            r_valid;
    result_t         r_data;
    result_t         out_reg, skid_reg;
    logic            out_valid_reg, skid_valid_reg;
    logic            take;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            a[i] = s_tdata[i*W +: W];
            u[i] = s_tdata[(4+i)*W +: W];
        end
    end

    assign en       = !skid_valid_reg;
    assign s_tready = en;
    assign take     = out_valid_reg && m_tready;

    vr4_dot u_dot (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid && s_tready),
        .a         (a),
        .u         (u),
        .out_valid (d_valid),
        .out_side  (d_side),
        .out_num   (d_num),
        .out_den   (d_den)
    );

    vr4_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (d_valid),
        .in_side   (d_side),
        .in_num    (d_num),
        .in_den    (d_den),
        .out_valid (q_valid),
        .out_side  (q_side),
        .out_quo   (q_quo)
    );

    vr4_resid u_resid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (q_valid),
        .in_side   (q_side),
        .in_quo    (q_quo),
        .out_valid (r_valid),
        .out_res   (r_data.res),
        .out_coef  (r_data.coef),
        .out_sat   (r_data.sat),
        .out_zero  (r_data.zero)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (take) begin
                out_reg        <= skid_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (r_valid) begin
            if (!out_valid_reg || take) begin
                out_reg       <= r_data;
                out_valid_reg <= 1'b1;
            end else begin
                skid_reg       <= r_data;
                skid_valid_reg <= 1'b1;
            end
        end else if (take) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.coef, out_reg.res[3], out_reg.res[2],
                       out_reg.res[1], out_reg.res[0]};
    assign m_tuser  = {out_reg.zero, out_reg.sat};

endmodule

FILE: hdl/vr4_dot.sv
// ----------------------------------------------------------------------------
// vr4_dot
// Products, dot sums and dividend set-up: three register stages.
// ----------------------------------------------------------------------------
module vr4_dot
    import vr4_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  vec_t            a,
    input  vec_t            u,
    output logic            out_valid,
    output side_t           out_side,
    output logic [NW-1:0]   out_num,
    output logic [SUUW-1:0] out_den
);

    logic                 v1_reg, v2_reg, v3_reg;
    vec_t                 a1_reg, u1_reg, a2_reg, u2_reg;
    logic signed [PW-1:0] pau_reg [4];
    logic signed [PW-1:0] puu_reg [4];
    logic signed [SAUW-1:0] sau_reg;
    logic [SUUW-1:0]      suu_reg;
    logic                 zero_reg;
    logic signed [SAUW-1:0] sau_next;
    logic [SUUW-1:0]      suu_next;
    logic [MAGW-1:0]      mag;
    logic [NW-1:0]        num;
    side_t                side_reg;
    logic [NW-1:0]        num_reg;
    logic [SUUW-1:0]      den_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_comb begin
        sau_next = '0;
        suu_next = '0;
        for (int i = 0; i < 4; i++) begin
            sau_next = sau_next + SAUW'(pau_reg[i]);
            suu_next = suu_next + SUUW'($unsigned(puu_reg[i]));
        end
        mag = sau_reg[SAUW-1] ? MAGW'(-sau_reg) : MAGW'(sau_reg);
        num = {mag, {F{1'b0}}};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a1_reg <= a;
            u1_reg <= u;
            for (int i = 0; i < 4; i++) begin
                pau_reg[i] <= $signed(a[i]) * $signed(u[i]);
                puu_reg[i] <= $signed(u[i]) * $signed(u[i]);
            end
            a2_reg   <= a1_reg;
            u2_reg   <= u1_reg;
            sau_reg  <= sau_next;
            suu_reg  <= suu_next;
            zero_reg <= (u1_reg == '0);
            side_reg.a    <= a2_reg;
            side_reg.u    <= u2_reg;
            side_reg.zero <= zero_reg;
            side_reg.neg  <= sau_reg[SAUW-1];
            // quotient would need more bits than the divider resolves
            side_reg.ovf  <= RW'(num) >= (RW'(suu_reg) << QB);
            num_reg <= num;
            den_reg <= suu_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_side  = side_reg;
    assign out_num   = num_reg;
    assign out_den   = den_reg;

endmodule

FILE: hdl/vr4_div.sv
// ----------------------------------------------------------------------------
// vr4_div
// Pipelined restoring divider, one quotient bit per stage, then rounding.
// ----------------------------------------------------------------------------
module vr4_div
    import vr4_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  side_t           in_side,
    input  logic [NW-1:0]   in_num,
    input  logic [SUUW-1:0] in_den,
    output logic            out_valid,
    output side_t           out_side,
    output logic [QB:0]     out_quo
);

    logic            v_reg   [QB];
    side_t           side_reg[QB];
    logic [RW-1:0]   rem_reg [QB];
    logic [QB-1:0]   quo_reg [QB];
    logic [SUUW-1:0] den_reg [QB];

    logic            vr_reg;
    side_t           sider_reg;
    logic [QB:0]     quor_reg;
    logic            round_up;

    for (genvar j = 0; j < QB; j++) begin : g_stage
        localparam int K = QB - 1 - j;
        logic            v_in;
        side_t           side_in;
        logic [RW-1:0]   rem_in;
        logic [QB-1:0]   quo_in;
        logic [SUUW-1:0] den_in;
        logic [RW-1:0]   trial;

        if (j == 0) begin : g_first
            assign v_in    = in_valid;
            assign side_in = in_side;
            assign rem_in  = RW'(in_num);
            assign quo_in  = '0;
            assign den_in  = in_den;
        end else begin : g_next
            assign v_in    = v_reg[j-1];
            assign side_in = side_reg[j-1];
            assign rem_in  = rem_reg[j-1];
            assign quo_in  = quo_reg[j-1];
            assign den_in  = den_reg[j-1];
        end

        assign trial = RW'(den_in) << K;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[j] <= 1'b0;
            end else if (en) begin
                v_reg[j] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[j] <= side_in;
                den_reg[j]  <= den_in;
                if (rem_in >= trial) begin
                    rem_reg[j]    <= rem_in - trial;
                    quo_reg[j]    <= quo_in | (QB'(1) << K);
                end else begin
                    rem_reg[j]    <= rem_in;
                    quo_reg[j]    <= quo_in;
                end
            end
        end
    end

    // nearest, ties away from zero: remainder at least half the divisor
    assign round_up = ((SUUW+1)'(rem_reg[QB-1][SUUW-1:0]) << 1) >= (SUUW+1)'(den_reg[QB-1]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vr_reg <= 1'b0;
        end else if (en) begin
            vr_reg <= v_reg[QB-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sider_reg <= side_reg[QB-1];
            quor_reg  <= (QB+1)'(quo_reg[QB-1]) + (QB+1)'(round_up);
        end
    end

    assign out_valid = vr_reg;
    assign out_side  = sider_reg;
    assign out_quo   = quor_reg;

endmodule

FILE: hdl/vr4_resid.sv
// ----------------------------------------------------------------------------
// vr4_resid
// Coefficient saturation, c*u products, subtraction, rounding and clamping; a zero direction passes a through.
// ----------------------------------------------------------------------------
module vr4_resid
    import vr4_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        in_valid,
    input  side_t       in_side,
    input  logic [QB:0] in_quo,
    output logic        out_valid,
    output vec_t        out_res,
    output logic [W-1:0] out_coef,
    output logic        out_sat,
    output logic        out_zero
);

    localparam logic [QB:0] POS_LIM = (QB+1)'({1'b0, {(W-1){1'b1}}});
    localparam logic [QB:0] NEG_LIM = POS_LIM + (QB+1)'(1);
    localparam logic [W-1:0] WMAX   = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] WMIN   = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [TW:0] RHALF = (TW+1)'(1) << (F - 1);
    localparam logic signed [TW:0] SMAX  = (TW+1)'($signed(WMAX));
    localparam logic signed [TW:0] SMIN  = -SMAX - (TW+1)'(1);

    logic                  v1_reg, v2_reg, v3_reg, v4_reg;
    // stage 1
    vec_t                  a1_reg, u1_reg;
    logic [W-1:0]          c1_reg;
    logic                  f1_reg, z1_reg;
    logic                  big;
    logic [W-1:0]          c_next;
    // stage 2
    vec_t                  a2_reg;
    logic signed [PW-1:0]  p2_reg [4];
    logic [W-1:0]          c2_reg;
    logic                  f2_reg, z2_reg;
    // stage 3
    vec_t                  a3_reg;
    logic signed [TW-1:0]  t3_reg [4];
    logic [W-1:0]          c3_reg;
    logic                  f3_reg, z3_reg;
    // stage 4
    vec_t                  res_reg;
    logic [W-1:0]          c4_reg;
    logic                  f4_reg, z4_reg;
    vec_t                  res_next;
    logic [3:0]            clip;

    always_comb begin
        big = in_side.ovf || (in_side.neg ? (in_quo > NEG_LIM) : (in_quo > POS_LIM));
        if (big) begin
            c_next = in_side.neg ? WMIN : WMAX;
        end else begin
            c_next = in_side.neg ? W'(-in_quo) : in_quo[W-1:0];
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            logic signed [TW:0] rnd;
            logic signed [TW:0] sh;
            rnd = (TW+1)'(t3_reg[i]) + (t3_reg[i][TW-1] ? RHALF - (TW+1)'(1) : RHALF);
            sh  = rnd >>> F;
            clip[i] = 1'b0;
            if (sh > SMAX) begin
                res_next[i] = WMAX;
                clip[i]     = 1'b1;
            end else if (sh < SMIN) begin
                res_next[i] = WMIN;
                clip[i]     = 1'b1;
            end else begin
                res_next[i] = sh[W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a1_reg <= in_side.a;
            u1_reg <= in_side.u;
            z1_reg <= in_side.zero;
            c1_reg <= in_side.zero ? '0 : c_next;
            f1_reg <= !in_side.zero && big;

            a2_reg <= a1_reg;
            c2_reg <= c1_reg;
            f2_reg <= f1_reg;
            z2_reg <= z1_reg;
            for (int i = 0; i < 4; i++) begin
                p2_reg[i] <= $signed(c1_reg) * $signed(u1_reg[i]);
            end

            a3_reg <= a2_reg;
            c3_reg <= c2_reg;
            f3_reg <= f2_reg;
            z3_reg <= z2_reg;
            for (int i = 0; i < 4; i++) begin
                t3_reg[i] <= TW'($signed({a2_reg[i], {F{1'b0}}})) - TW'(p2_reg[i]);
            end

            c4_reg <= c3_reg;
            z4_reg <= z3_reg;
            if (z3_reg) begin
                res_reg <= a3_reg;
                f4_reg  <= 1'b0;
            end else begin
                res_reg <= res_next;
                f4_reg  <= f3_reg || (clip != '0);
            end
        end
    end

    assign out_valid = v4_reg;
    assign out_res   = res_reg;
    assign out_coef  = c4_reg;
    assign out_sat   = f4_reg;
    assign out_zero  = z4_reg;

endmodule

FILE: hdl/vr4_checker.sv
// ----------------------------------------------------------------------------
// vr4_checker
// Port-level checks of the vector rejection block, bound to the top level.
// ----------------------------------------------------------------------------
module vr4_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [159:0] m_tdata,
    input logic [1:0]   m_tuser
);

    function automatic logic at_limit(logic [31:0] w);
        return (w == 32'h7fff_ffff) || (w == 32'h8000_0000);
    endfunction

    // zero direction returns c = 0 and never clamps
    a_zero_coef: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> (m_tdata[159:128] == 32'd0 && !m_tuser[0]))
        else $error("zero direction with non-zero coefficient or clamp");

    // nothing emerges right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result presented straight after reset");

    // held transaction stays put while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

    // a clamp leaves the coefficient or some component at a word limit
    a_sat_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |->
            (at_limit(m_tdata[159:128]) || at_limit(m_tdata[31:0]) ||
             at_limit(m_tdata[63:32]) || at_limit(m_tdata[95:64]) ||
             at_limit(m_tdata[127:96])))
        else $error("clamp flagged with no value at a word limit");

endmodule

bind vector_rejection_4d vr4_checker u_vr4_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

FILE: tb/tb_vector_rejection_4d.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_vector_rejection_4d
// Streams vector pairs through the rejection pipeline under varying stalls and
// checks every result against hand-set values or a wide-integer behavioural predictor.
// ----------------------------------------------------------------------------
module tb_vector_rejection_4d;
    import vr4_pkg::*;

    localparam int LIMIT = 2_000_000;
    localparam int N_RANDOM = 1030;

    typedef struct packed {
        logic [31:0] coef;
        logic [3:0][31:0] res;
        logic sat;
        logic zdir;
    } rej_t;

    typedef struct {
        logic [255:0] data;
        bit           known;
        rej_t         result;
    } row_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [255:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [159:0] m_tdata;
    logic [1:0]   m_tuser;

    rej_t   pending_q[$];
    int     errors = 0;
    int     cycles = 0;
    int     send_idle = 36;
    int     recv_idle = 86;
    bit     hold_recv = 1'b0;
    row_t   rows[$];

    vector_rejection_4d dut (.*);

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic signed [127:0] round_half_away(
            logic signed [127:0] v, int n);
        logic [127:0] m;
        m = v < 0 ? -v : v;
        m = (m + (128'd1 << (n - 1))) >> n;
        return v < 0 ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic [31:0] clamp32(logic signed [127:0] v, ref bit flag);
        if (v > 128'sd2147483647) begin
            flag = 1'b1;
            return 32'h7fff_ffff;
        end
        if (v < -128'sd2147483648) begin
            flag = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic rej_t reject_vector(logic [255:0] d);
        logic signed [127:0] av[4], uv[4], sau, suu, q, r, t;
        logic [127:0] mag;
        logic signed [127:0] c;
        bit flag;
        rej_t o;
        flag = 1'b0;
        sau = 0;
        suu = 0;
        for (int i = 0; i < 4; i++) begin
            av[i] = $signed(d[32*i +: 32]);
            uv[i] = $signed(d[128 + 32*i +: 32]);
            sau += av[i] * uv[i];
            suu += uv[i] * uv[i];
        end
        o = '0;
        if (suu == 0) begin
            for (int i = 0; i < 4; i++) o.res[i] = av[i][31:0];
            o.zdir = 1'b1;
            return o;
        end
        mag = (sau < 0 ? -sau : sau) << F;
        q = mag / suu;
        r = mag % suu;
        if (2 * r >= suu) q += 1;
        o.coef = clamp32(sau < 0 ? -q : q, flag);
        c = $signed(o.coef);
        for (int i = 0; i < 4; i++) begin
            t = (av[i] <<< F) - c * uv[i];
            o.res[i] = clamp32(round_half_away(t, F), flag);
        end
        o.sat = flag;
        return o;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            1: return $urandom_range(0, 3) - 2;
            2: return {{16{1'b0}}, 16'($urandom)} - 32'h8000;
            3: return {{8{1'b0}}, 24'($urandom)} - 32'h80_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [255:0] rand_pair();
        logic [255:0] d;
        for (int i = 0; i < 8; i++) d[32*i +: 32] = rand_word();
        // zero direction now and then
        if ($urandom_range(0, 19) == 0) d[255:128] = '0;
        return d;
    endfunction

    task automatic push_row(logic [255:0] d, bit known, rej_t r);
        row_t x;
        x.data = d;
        x.known = known;
        x.result = r;
        rows.push_back(x);
    endtask

    // valid stays high into the next transaction unless the sender idles
    task automatic send_pair(logic [255:0] d, rej_t e);
        while ($urandom_range(0, 99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        pending_q.push_back(e);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // receiver
    always @(negedge aclk) begin
        if (!aresetn || hold_recv) m_tready <= 1'b0;
        else m_tready <= ($urandom_range(0, 99) >= recv_idle);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_q.size() == 0) begin
                $error("unexpected result transaction");
                errors++;
            end else begin
                rej_t e;
                e = pending_q.pop_front();
                for (int i = 0; i < 4; i++)
                    if (m_tdata[32*i +: 32] !== e.res[i]) begin
                        $error("res_%0d exp %h got %h", i, e.res[i], m_tdata[32*i +: 32]);
                        errors++;
                    end
                if (m_tdata[159:128] !== e.coef) begin
                    $error("coef exp %h got %h", e.coef, m_tdata[159:128]);
                    errors++;
                end
                if (m_tuser[0] !== e.sat) begin
                    $error("saturated exp %b got %b", e.sat, m_tuser[0]);
                    errors++;
                end
                if (m_tuser[1] !== e.zdir) begin
                    $error("zero_direction exp %b got %b", e.zdir, m_tuser[1]);
                    errors++;
                end
            end
        end
    end

    initial begin
        rej_t e;
        logic [255:0] d;
        e = '0;
        // zero direction: a passes through
        d = {128'd0, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h0001_0000};
        e.res = d[127:0];
        e.zdir = 1'b1;
        push_row(d, 1'b1, e);
        push_row('0, 1'b1, '{coef: 0, res: '0, sat: 0, zdir: 1});
        // a parallel to u: zero residual, coef 1.0
        e = '0;
        e.coef = 32'h0001_0000;
        push_row({4{32'h0001_0000}} | 256'd0 | ({4{32'h0001_0000}} << 128), 1'b1, e);
        // a orthogonal to u: residual is a, coef 0
        e = '0;
        e.res = {32'd0, 32'd0, 32'h0001_0000, 32'd0};
        push_row({32'd0, 32'h0001_0000, 128'd0, 32'h0001_0000, 32'd0}, 1'b1, e);
        push_row({{8{32'h7fff_ffff}}}, 1'b0, '0);
        push_row({{8{32'h8000_0000}}}, 1'b0, '0);
        push_row({{4{32'h0000_0001}}, {4{32'h7fff_ffff}}}, 1'b0, '0);   // coef saturates
        push_row({{4{32'h0000_0001}}, {4{32'h8000_0000}}}, 1'b0, '0);
        push_row({96'd0, 32'h0000_0001, 96'd0, 32'h8000_0000}, 1'b0, '0);
        push_row({{4{32'hffff_ffff}}, {4{32'h0000_8000}}}, 1'b0, '0);
        push_row({{4{32'h0000_0003}}, {4{32'h0000_0001}}}, 1'b0, '0);
        push_row({{4{32'h8000_0000}}, {4{32'h7fff_ffff}}}, 1'b0, '0);
        push_row({32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 32'hffff_ffff,
                  32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h0000_0001}, 1'b0, '0);

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (rows[k])
            send_pair(rows[k].data, rows[k].known ? rows[k].result : reject_vector(rows[k].data));

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 3) begin
                send_idle = 86;
                recv_idle = 36;
            end
            if (n == 2 * N_RANDOM / 3) begin
                send_idle = 0;
                recv_idle = 0;
            end
            if (n == 500) begin
                // sender waits for the pipeline to drain
                s_tvalid <= 1'b0;
                while (pending_q.size() != 0) @(posedge aclk);
                @(negedge aclk);
            end
            if (n == 800) begin
                // long receiver hold-off so the pipeline fills and back-pressures
                fork
                    begin
                        hold_recv = 1'b1;
                        repeat (150) @(posedge aclk);
                        hold_recv = 1'b0;
                    end
                join_none
            end
            d = rand_pair();
            send_pair(d, reject_vector(d));
        end

        s_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
